>>> src/swlog_pkg.sv
// Shared types, constants and sizes for the sliding window log rate limiter.
package swlog_pkg;

    localparam int LOG_DEPTH = 64;
    localparam int TIME_BITS = 48;

    localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int REQ_W = 7;
    localparam int WIN_W = 32;
    localparam int CMP_W = ((CNT_W > REQ_W) ? CNT_W : REQ_W) + 1;
    localparam int AGE_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

    localparam logic CMD_TRY   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic {
        CFG_MAX_REQUESTS = 1'b0,
        CFG_WINDOW_TICKS = 1'b1
    } swlog_cfg_idx_t;

    localparam logic [REQ_W-1:0] MAX_REQ_RESET = REQ_W'(64);
    localparam logic [WIN_W-1:0] WINDOW_RESET  = WIN_W'(1000000);

    typedef struct packed {
        logic                 command;
        logic [TIME_BITS-1:0] now_time;
        logic [REQ_W-1:0]     request_count;
    } swlog_in_t;

    typedef struct packed {
        logic             allowed;
        logic [6:0]       current_count;
        logic [WIN_W-1:0] ticks_until_oldest_expires;
    } swlog_out_t;

    typedef struct packed {
        logic                 we;
        logic [IDX_W-1:0]     waddr;
        logic [TIME_BITS-1:0] wdata;
        logic [IDX_W-1:0]     raddr;
    } swlog_mem_ctl_t;

    typedef struct packed {
        logic             expired;
        logic [WIN_W-1:0] remaining;
    } swlog_age_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DECIDE,
        S_PUSH,
        S_DONE
    } swlog_state_t;

endpackage

>>> src/swlog_ring.sv
// Timestamp ring memory: one write port, one registered read port.
module swlog_ring
    import swlog_pkg::*;
(
    input  logic                 clk,
    input  swlog_mem_ctl_t       ctl,
    output logic [TIME_BITS-1:0] rd_data
);

    logic [TIME_BITS-1:0] mem [LOG_DEPTH];
    logic [TIME_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rd_data_reg <= mem[ctl.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/swlog_age.sv
// Age compare unit: wrap-safe age of a stamp against the window.
module swlog_age
    import swlog_pkg::*;
(
    input  logic [TIME_BITS-1:0] now_time,
    input  logic [TIME_BITS-1:0] stamp,
    input  logic [WIN_W-1:0]     window_ticks,
    output swlog_age_t           res
);

    logic [TIME_BITS-1:0] age;
    logic [AGE_W-1:0]     age_ext;
    logic [AGE_W-1:0]     win_ext;

    always_comb
    begin
        age           = now_time - stamp;   // modulo 2^TIME_BITS
        age_ext       = AGE_W'(age);
        win_ext       = AGE_W'(window_ticks);
        res.expired   = age_ext > win_ext;
        // only used when not expired, so the age fits the window width
        res.remaining = window_ticks - age_ext[WIN_W-1:0];
    end

endmodule

>>> src/swlog_seq.sv
// Sequencer: expiry walk, admission check, entry pushes and result register.
module swlog_seq
    import swlog_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  swlog_in_t            item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output swlog_out_t           result,
    input  logic [REQ_W-1:0]     max_requests,
    input  logic [WIN_W-1:0]     window_ticks,
    output swlog_mem_ctl_t       mem_ctl,
    input  logic [TIME_BITS-1:0] rd_data,
    input  swlog_age_t           age_res,
    output logic [TIME_BITS-1:0] age_now
);

    swlog_state_t      state_reg, state_next;
    logic [IDX_W-1:0]  oldest_reg, oldest_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [REQ_W-1:0]  left_reg, left_next;
    swlog_in_t         item_reg, item_next;
    logic              allowed_reg, allowed_next;
    logic [WIN_W-1:0]  rem_reg, rem_next;
    logic              result_valid_reg, result_valid_next;
    swlog_out_t        result_reg, result_next;

    logic [CMP_W-1:0]  limit;
    logic [CMP_W-1:0]  want;
    logic              admit;
    logic [SUM_W-1:0]  wsum;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  oldest_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            oldest_reg       <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            oldest_reg       <= oldest_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg    <= left_next;
        item_reg    <= item_next;
        allowed_reg <= allowed_next;
        rem_reg     <= rem_next;
        result_reg  <= result_next;
    end

    always_comb
    begin
        // limit clamps at the log depth
        if (CMP_W'(max_requests) > CMP_W'(LOG_DEPTH))
        begin
            limit = CMP_W'(LOG_DEPTH);
        end
        else
        begin
            limit = CMP_W'(max_requests);
        end
        want  = CMP_W'(count_reg) + CMP_W'(item_reg.request_count);
        admit = (item_reg.request_count != '0) && (want <= limit);

        wsum = SUM_W'(oldest_reg) + SUM_W'(count_reg);
        if (wsum >= SUM_W'(LOG_DEPTH))
        begin
            wsum = wsum - SUM_W'(LOG_DEPTH);
        end
        waddr = wsum[IDX_W-1:0];

        if (oldest_reg == IDX_W'(LOG_DEPTH - 1))
        begin
            oldest_inc = '0;
        end
        else
        begin
            oldest_inc = oldest_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        oldest_next       = oldest_reg;
        count_next        = count_reg;
        left_next         = left_reg;
        item_next         = item_reg;
        allowed_next      = allowed_reg;
        rem_next          = rem_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        mem_ctl.we    = 1'b0;
        mem_ctl.waddr = waddr;
        mem_ctl.wdata = item_reg.now_time;
        mem_ctl.raddr = oldest_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next    = item;
                    allowed_next = 1'b0;
                    rem_next     = '0;
                    if (item.command == CMD_CLEAR)
                    begin
                        count_next  = '0;
                        oldest_next = '0;
                        state_next  = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (age_res.expired)
                begin
                    oldest_next = oldest_inc;
                    count_next  = count_reg - CNT_W'(1);
                    state_next  = (count_reg == CNT_W'(1)) ? S_DECIDE : S_READ;
                end
                else
                begin
                    rem_next   = age_res.remaining;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // surviving oldest entry keeps its age; a fresh log starts at a full window
                if (count_reg == '0)
                begin
                    rem_next = admit ? window_ticks : '0;
                end
                allowed_next = admit;
                left_next    = item_reg.request_count;
                state_next   = admit ? S_PUSH : S_DONE;
            end
            S_PUSH:
            begin
                mem_ctl.we = 1'b1;
                count_next = count_reg + CNT_W'(1);
                left_next  = left_reg - REQ_W'(1);
                if (left_reg == REQ_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.allowed                    = allowed_reg;
                    result_next.current_count              = 7'(count_reg);
                    result_next.ticks_until_oldest_expires = rem_reg;
                    result_valid_next                      = 1'b1;
                    state_next                             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign age_now      = item_reg.now_time;

endmodule

>>> src/sliding_window_log_rate_limiter.sv
// Flow from accept to result: a clear goes straight to the result register; a try walks the
// expired entries (read, check), reads and checks the surviving oldest entry if there is one,
// decides, pushes one entry per admitted request, then registers the result. Throughput: one
// word at a time, next word taken the cycle after the result registers; a full output
// register holding its word stalls the finish. Reset: async active low; log empty,
// limit 64, window 1000000 ticks. Top level of the sliding window log rate limiter.
module sliding_window_log_rate_limiter
    import swlog_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  swlog_in_t        item,
    output logic             result_valid,
    input  logic             result_ready,
    output swlog_out_t       result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  swlog_cfg_idx_t   cfg_index,
    input  logic [WIN_W-1:0] cfg_data
);

    logic [REQ_W-1:0]     max_requests_reg;
    logic [WIN_W-1:0]     window_ticks_reg;
    swlog_mem_ctl_t       mem_ctl;
    logic [TIME_BITS-1:0] rd_data;
    logic [TIME_BITS-1:0] age_now;
    swlog_age_t           age_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_requests_reg <= MAX_REQ_RESET;
            window_ticks_reg <= WINDOW_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_REQUESTS: max_requests_reg <= cfg_data[REQ_W-1:0];
                CFG_WINDOW_TICKS: window_ticks_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    swlog_ring u_ring (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_data (rd_data)
    );

    swlog_age u_age (
        .now_time     (age_now),
        .stamp        (rd_data),
        .window_ticks (window_ticks_reg),
        .res          (age_res)
    );

    swlog_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .max_requests (max_requests_reg),
        .window_ticks (window_ticks_reg),
        .mem_ctl      (mem_ctl),
        .rd_data      (rd_data),
        .age_res      (age_res),
        .age_now      (age_now)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.current_count <= 7'(LOG_DEPTH)))
        else $error("current_count above log depth");

    a_allowed_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.allowed) |-> (result.current_count != '0))
        else $error("admitted word reports an empty log");

    a_empty_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.current_count == '0))
            |-> (result.ticks_until_oldest_expires == '0))
        else $error("empty log reports ticks until expiry");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("ready again right after accepting a word");

endmodule
